// ===== hdl/jsu_pkg.sv =====
// Package for the JSON string unescaper: payload structs, front phases, queue entry
// format and UTF-8 byte helpers. It depends on nothing else.
package jsu_pkg;

    localparam int JSU_QDEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
    } t_out;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_BODY    = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX1    = 4'd3,
        PH_PAIR_BS = 4'd4,
        PH_PAIR_U  = 4'd5,
        PH_HEX2    = 4'd6
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_CP   = 3'd1,
        K_END  = 3'd2,
        K_ERR  = 3'd3,
        K_RAW  = 3'd4
    } t_kind;

    typedef struct packed {
        logic        pre_fffd;
        t_kind       kind;
        logic [20:0] cp;
    } t_cmd;

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [20:0] CP_REPL  = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP  = 21'h010000;

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= 21'h00007F) begin
            len = 3'd1;
        end else if (cp <= 21'h0007FF) begin
            len = 3'd2;
        end else if (cp <= 21'h00FFFF) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] k);
        logic [7:0] b;
        logic [1:0] j;
        j = 2'(len - 3'd1 - {1'b0, k});
        if (k == 2'd0) begin
            case (len)
                3'd1:    b = {1'b0, cp[6:0]};
                3'd2:    b = {3'b110, cp[10:6]};
                3'd3:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            case (j)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

// ===== hdl/json_string_unescape_utf8_top.sv =====
// JSON string literal unescaper with UTF-8 output.
// Input channel: i_valid/o_ready with i_data (in_byte, start_string). A transaction with
// start_string set must carry the opening double quote and begins a new literal.
// Output channel: o_valid/i_ready with o_data (out_byte, status, last_of_run). Status 0
// carries a decoded byte, 1 marks the closing quote, 2 marks malformed input; the last
// result caused by one input byte has last_of_run set.
// The front end takes one input byte per cycle whenever the command queue has room and
// pushes one command per byte that yields results. The back end drains the queue at one
// output byte per cycle while the receiver accepts them, into an output register, so a
// result passes through its queue entry and then the output register. Plain text sustains
// one byte per cycle while the receiver keeps up; longer runs are bounded by the single
// output byte per cycle and smoothed by the DEPTH-entry queue.
// Reset clears the decoder to idle, empties the queue and drops the output register; no
// clearing pass is needed. When the receiver stalls, the output register holds its
// result, the queue fills and o_ready falls once it is full.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    logic push, pop, empty, full;
    t_cmd cmd, head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    jsu_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

endmodule

// ===== hdl/jsu_front.sv =====
// Front end of the JSON string unescaper: accepts input bytes, runs the escape
// and surrogate state machine and pushes one command per byte that yields output. Uses jsu_pkg.
module jsu_front
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_cu, n_cu;
    logic [9:0]  r_hs, n_hs;
    logic [1:0]  r_cnt, n_cnt;

    logic [7:0]  b;
    logic        acc;
    logic        hv;
    logic [3:0]  hd;
    logic [15:0] new_cu;
    logic        done;
    t_kind       bk, ek, uk;
    t_phase      bph, eph, uph;
    logic [7:0]  ebyte;
    logic [20:0] ucp;
    t_cmd        cmd;

    assign b       = i_data.in_byte;
    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;
    assign new_cu  = {r_cu[11:0], hd};
    assign done    = (r_cnt == 2'd3);

    always_comb begin
        hv = 1'b1;
        hd = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hd = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hd = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hd = 4'(b - 8'h37);
        end else begin
            hv = 1'b0;
        end
    end

    always_comb begin
        bk  = K_RAW;
        bph = PH_BODY;
        if (b == CH_QUOTE) begin
            bk  = K_END;
            bph = PH_IDLE;
        end else if (b < CH_SPACE) begin
            bk  = K_ERR;
            bph = PH_IDLE;
        end else if (b == CH_BSLASH) begin
            bk  = K_NONE;
            bph = PH_ESC;
        end
        case (b)
            CH_LOW_B: ebyte = 8'h08;
            CH_LOW_F: ebyte = 8'h0C;
            CH_LOW_N: ebyte = 8'h0A;
            CH_LOW_R: ebyte = 8'h0D;
            CH_LOW_T: ebyte = 8'h09;
            default:  ebyte = b;
        endcase
        ek  = (b == CH_LOW_U) ? K_NONE : K_RAW;
        eph = (b == CH_LOW_U) ? PH_HEX1 : PH_BODY;
        if (new_cu >= 16'hD800 && new_cu <= 16'hDBFF) begin
            uk  = K_NONE;
            ucp = {5'd0, new_cu};
            uph = PH_PAIR_BS;
        end else if (new_cu >= 16'hDC00 && new_cu <= 16'hDFFF) begin
            uk  = K_CP;
            ucp = CP_REPL;
            uph = PH_BODY;
        end else begin
            uk  = K_CP;
            ucp = {5'd0, new_cu};
            uph = PH_BODY;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cu    = r_cu;
        n_hs    = r_hs;
        n_cnt   = r_cnt;
        cmd     = '0;
        cmd.kind = K_NONE;
        if (i_data.start_string) begin
            n_cu  = '0;
            n_hs  = '0;
            n_cnt = '0;
            if (b == CH_QUOTE) begin
                n_phase = PH_BODY;
            end else begin
                cmd.kind = K_ERR;
                n_phase  = PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_BODY: begin
                    cmd.kind = bk;
                    cmd.cp   = {13'd0, b};
                    n_phase  = bph;
                end
                PH_ESC: begin
                    cmd.kind = ek;
                    cmd.cp   = {13'd0, ebyte};
                    n_phase  = eph;
                    if (b == CH_LOW_U) begin
                        n_cu  = '0;
                        n_cnt = '0;
                    end
                end
                PH_HEX1: begin
                    if (!hv) begin
                        cmd.kind = K_ERR;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_cu = new_cu;
                        if (done) begin
                            n_cnt    = '0;
                            cmd.kind = uk;
                            cmd.cp   = ucp;
                            n_phase  = uph;
                            if (uk == K_NONE) begin
                                n_hs = new_cu[9:0];
                            end
                        end else begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                end
                PH_PAIR_BS: begin
                    if (b == CH_BSLASH) begin
                        n_phase = PH_PAIR_U;
                    end else begin
                        cmd.pre_fffd = 1'b1;
                        cmd.kind     = bk;
                        cmd.cp       = {13'd0, b};
                        n_phase      = bph;
                    end
                end
                PH_PAIR_U: begin
                    if (b == CH_LOW_U) begin
                        n_cu    = '0;
                        n_cnt   = '0;
                        n_phase = PH_HEX2;
                    end else begin
                        cmd.pre_fffd = 1'b1;
                        cmd.kind     = ek;
                        cmd.cp       = {13'd0, ebyte};
                        n_phase      = eph;
                    end
                end
                PH_HEX2: begin
                    if (!hv) begin
                        cmd.pre_fffd = 1'b1;
                        cmd.kind     = K_ERR;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_cu = new_cu;
                        if (done) begin
                            n_cnt = '0;
                            if (new_cu >= 16'hDC00 && new_cu <= 16'hDFFF) begin
                                cmd.kind = K_CP;
                                cmd.cp   = CP_SUPP + {1'b0, r_hs, new_cu[9:0]};
                                n_phase  = PH_BODY;
                            end else begin
                                cmd.pre_fffd = 1'b1;
                                cmd.kind     = uk;
                                cmd.cp       = ucp;
                                n_phase      = uph;
                                if (uk == K_NONE) begin
                                    n_hs = new_cu[9:0];
                                end
                            end
                        end else begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                end
                default: begin
                    cmd.kind = K_ERR;
                    n_phase  = PH_IDLE;
                end
            endcase
        end
    end

    assign o_cmd  = cmd;
    assign o_push = acc && (cmd.pre_fffd || cmd.kind != K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cu    <= '0;
            r_hs    <= '0;
            r_cnt   <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_cu    <= n_cu;
            r_hs    <= n_hs;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hdl/jsu_fifo.sv =====
// Command queue between the front and back ends of the JSON string unescaper.
// Holds DEPTH commands in a small register array. Uses jsu_pkg.
module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? ((r_wr == LAST) ? '0 : r_wr + AW'(1)) : r_wr;
        n_rd  = do_pop ? ((r_rd == LAST) ? '0 : r_rd + AW'(1)) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("jsu_fifo: push while full");

endmodule

// ===== hdl/jsu_back.sv =====
// Back end of the JSON string unescaper: expands the queue head command into UTF-8 bytes
// and status results, one per cycle unless stalled, into an output register. Uses jsu_pkg.
module jsu_back
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    t_out       r_data, res;
    logic [2:0] pre_len, cp_len, total, k, len;
    logic       load, last;

    assign len     = utf8_len(i_head.cp);
    assign pre_len = i_head.pre_fffd ? 3'd3 : 3'd0;
    assign total   = pre_len + cp_len;
    assign k       = r_idx - pre_len;
    assign last    = (r_idx == total - 3'd1);
    assign load    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = load && last;

    always_comb begin
        case (i_head.kind)
            K_CP:    cp_len = len;
            K_RAW:   cp_len = 3'd1;
            K_END:   cp_len = 3'd1;
            K_ERR:   cp_len = 3'd1;
            default: cp_len = 3'd0;
        endcase
        res.last_of_run = last;
        if (r_idx < pre_len) begin
            res.out_byte = utf8_byte(CP_REPL, 3'd3, r_idx[1:0]);
            res.status   = ST_BYTE;
        end else begin
            case (i_head.kind)
                K_END: begin
                    res.out_byte = 8'd0;
                    res.status   = ST_END;
                end
                K_ERR: begin
                    res.out_byte = 8'd0;
                    res.status   = ST_ERR;
                end
                K_RAW: begin
                    res.out_byte = i_head.cp[7:0];
                    res.status   = ST_BYTE;
                end
                default: begin
                    res.out_byte = utf8_byte(i_head.cp, len, k[1:0]);
                    res.status   = ST_BYTE;
                end
            endcase
        end
        n_idx = r_idx;
        if (load) begin
            n_idx = last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < total))
        else $error("jsu_back: byte index beyond command length");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == 3'd0))
        else $error("jsu_back: byte index not cleared with queue empty");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.status != ST_BYTE) |-> (r_data.last_of_run && r_data.out_byte == 8'd0))
        else $error("jsu_back: status result not final or carries a byte");

endmodule

// ===== bench/json_string_unescape_utf8_top_test.sv =====
// Self-checking testbench for json_string_unescape_utf8_top, with a predictor of the
// UTF-8 unescaper and a scoreboard kept in json_unescape_check_pkg.
// Depends on jsu_pkg and the RTL of the block; it reads and writes no files.
package json_unescape_check_pkg;
    import jsu_pkg::*;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
    localparam logic [20:0] CP_PLANE1   = 21'h010000;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CTL_BS   = 8'h08;
    localparam logic [7:0] CTL_TAB  = 8'h09;
    localparam logic [7:0] CTL_LF   = 8'h0A;
    localparam logic [7:0] CTL_FF   = 8'h0C;
    localparam logic [7:0] CTL_CR   = 8'h0D;
    localparam logic [7:0] CTL_MAX  = 8'h1F;

    function automatic int hex_digit_value(logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
        if (b >= CH_LC_A && b <= CH_LC_F) return int'(b - CH_LC_A) + 10;
        if (b >= CH_UC_A && b <= CH_UC_F) return int'(b - CH_UC_A) + 10;
        return -1;
    endfunction

    class utf8_scoreboard;
        t_phase      ph;
        logic [15:0] code_val;
        logic [15:0] high_val;
        logic [1:0]  ndigits;
        t_out        expected_q[$];
        logic [7:0]  run_byte[6];
        logic [1:0]  run_status[6];
        int          run_len;
        int          errors;
        int          n_inputs;
        int          n_text;
        int          n_ends;
        int          n_malformed;

        function new();
            ph = PH_IDLE;
            code_val = '0;
            high_val = '0;
            ndigits = '0;
            run_len = 0;
            errors = 0;
            n_inputs = 0;
            n_text = 0;
            n_ends = 0;
            n_malformed = 0;
        endfunction

        function void emit(logic [7:0] b, logic [1:0] st);
            if (run_len < 6) begin
                run_byte[run_len] = (st == ST_BYTE) ? b : 8'h00;
                run_status[run_len] = st;
                run_len++;
            end
        endfunction

        function void put_code_point(logic [20:0] cp);
            if (cp <= 21'h00007F) begin
                emit(cp[7:0], ST_BYTE);
            end else if (cp <= 21'h0007FF) begin
                emit(8'hC0 | 8'(cp >> 6), ST_BYTE);
                emit(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
            end else if (cp <= 21'h00FFFF) begin
                emit(8'hE0 | 8'(cp >> 12), ST_BYTE);
                emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_BYTE);
                emit(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
            end else begin
                emit(8'hF0 | 8'((cp >> 18) & 21'h07), ST_BYTE);
                emit(8'h80 | 8'((cp >> 12) & 21'h3F), ST_BYTE);
                emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_BYTE);
                emit(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
            end
        endfunction

        function void malformed();
            emit(8'h00, ST_ERR);
            ph = PH_IDLE;
        endfunction

        function void body_char(logic [7:0] b);
            if (b == CH_QUOTE) begin
                emit(8'h00, ST_END);
                ph = PH_IDLE;
            end else if (b < CH_SPACE) begin
                malformed();
            end else if (b == CH_BSLASH) begin
                ph = PH_ESC;
            end else begin
                emit(b, ST_BYTE);
            end
        endfunction

        function void escape_char(logic [7:0] b);
            logic [7:0] v;
            v = b;
            case (b)
                CH_LOW_B: v = CTL_BS;
                CH_LOW_F: v = CTL_FF;
                CH_LOW_N: v = CTL_LF;
                CH_LOW_R: v = CTL_CR;
                CH_LOW_T: v = CTL_TAB;
                CH_LOW_U: begin
                    code_val = '0;
                    ndigits = '0;
                    ph = PH_HEX1;
                    return;
                end
                default: v = b;
            endcase
            emit(v, ST_BYTE);
            ph = PH_BODY;
        endfunction

        function void finish_unit(logic [15:0] cu);
            if (cu >= SURR_HI_MIN && cu <= SURR_HI_MAX) begin
                high_val = cu;
                ph = PH_PAIR_BS;
            end else if (cu >= SURR_LO_MIN && cu <= SURR_LO_MAX) begin
                put_code_point(CP_REPLACE);
                ph = PH_BODY;
            end else begin
                put_code_point(21'(cu));
                ph = PH_BODY;
            end
        endfunction

        // Returns -1 on a bad digit, 1 once the fourth digit is in, 0 otherwise.
        function int collect_digit(logic [7:0] b);
            int d;
            d = hex_digit_value(b);
            if (d < 0) return -1;
            code_val = {code_val[11:0], 4'(d)};
            if (ndigits == 2'd3) begin
                ndigits = 2'd0;
                return 1;
            end
            ndigits = ndigits + 2'd1;
            return 0;
        endfunction

        function void note_input(t_in x);
            logic [7:0] b;
            int         r;
            t_out       e;
            b = x.in_byte;
            run_len = 0;
            n_inputs++;
            if (x.start_string) begin
                code_val = '0;
                high_val = '0;
                ndigits = '0;
                if (b == CH_QUOTE) ph = PH_BODY;
                else malformed();
            end else begin
                case (ph)
                    PH_BODY: body_char(b);
                    PH_ESC:  escape_char(b);
                    PH_HEX1: begin
                        r = collect_digit(b);
                        if (r == 1) finish_unit(code_val);
                        else if (r < 0) malformed();
                    end
                    PH_PAIR_BS: begin
                        if (b == CH_BSLASH) begin
                            ph = PH_PAIR_U;
                        end else begin
                            put_code_point(CP_REPLACE);
                            ph = PH_BODY;
                            body_char(b);
                        end
                    end
                    PH_PAIR_U: begin
                        if (b == CH_LOW_U) begin
                            code_val = '0;
                            ndigits = '0;
                            ph = PH_HEX2;
                        end else begin
                            put_code_point(CP_REPLACE);
                            ph = PH_BODY;
                            escape_char(b);
                        end
                    end
                    PH_HEX2: begin
                        r = collect_digit(b);
                        if (r == 1) begin
                            if (code_val >= SURR_LO_MIN && code_val <= SURR_LO_MAX) begin
                                put_code_point(CP_PLANE1
                                    + ((21'(high_val) - 21'(SURR_HI_MIN)) << 10)
                                    + (21'(code_val) - 21'(SURR_LO_MIN)));
                                ph = PH_BODY;
                            end else begin
                                put_code_point(CP_REPLACE);
                                finish_unit(code_val);
                            end
                        end else if (r < 0) begin
                            put_code_point(CP_REPLACE);
                            malformed();
                        end
                    end
                    default: malformed();
                endcase
            end
            for (int i = 0; i < run_len; i++) begin
                e.out_byte = run_byte[i];
                e.status = run_status[i];
                e.last_of_run = (i == run_len - 1);
                expected_q.push_back(e);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(t_out got);
            t_out e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result byte=%02h status=%0d last=%0b",
                                 got.out_byte, got.status, got.last_of_run));
                return;
            end
            e = expected_q.pop_front();
            if (e.status == ST_BYTE) n_text++;
            else if (e.status == ST_END) n_ends++;
            else n_malformed++;
            if (got.out_byte !== e.out_byte)
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, e.out_byte));
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.last_of_run !== e.last_of_run)
                report($sformatf("last_of_run %0b, expected %0b",
                                 got.last_of_run, e.last_of_run));
        endtask
    endclass
endpackage

module json_string_unescape_utf8_top_test;
    import jsu_pkg::*;
    import json_unescape_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 70;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    logic i_ready = 1'b0;

    logic        rx_hold = 1'b0;
    int          snd_idle = 15;
    int          rcv_idle = 67;
    int          n_sent = 0;
    int unsigned cycles = 0;
    utf8_scoreboard sb = new();

    json_string_unescape_utf8_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_ready(i_ready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, sb.expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        i_ready <= !rx_hold && ($urandom_range(99) >= rcv_idle);
    end

    task automatic hold_receiver(input int n);
        rx_hold <= 1'b1;
        repeat (n) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic send(input t_in x);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= x;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(x);
        n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in x;
        x.in_byte = b;
        x.start_string = 1'b0;
        send(x);
    endtask

    task automatic send_start(input logic [7:0] b);
        t_in x;
        x.in_byte = b;
        x.start_string = 1'b1;
        send(x);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return (upper ? CH_UC_A : CH_LC_A) + 8'(n) - 8'd10;
    endfunction

    task automatic send_unit(input logic [15:0] u);
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_U);
        for (int i = 3; i >= 0; i--) send_byte(hex_char(u[i*4 +: 4], 1'($urandom_range(1))));
    endtask

    task automatic send_bad_group();
        logic [7:0] b;
        int         k;
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_U);
        k = $urandom_range(3);
        for (int i = 0; i < k; i++)
            send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        do b = 8'($urandom_range(255)); while (hex_digit_value(b) >= 0);
        send_byte(b);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(8'hFF, CH_SPACE)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] simple_escape(int i);
        case (i)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_LOW_B;
            4:       return CH_LOW_F;
            5:       return CH_LOW_N;
            6:       return CH_LOW_R;
            default: return CH_LOW_T;
        endcase
    endfunction

    function automatic logic [15:0] scalar_unit();
        logic [15:0] u;
        case ($urandom_range(2))
            0:       u = 16'($urandom_range(16'h007F, 16'h0000));
            1:       u = 16'($urandom_range(16'h07FF, 16'h0080));
            default: begin
                do u = 16'($urandom_range(16'hFFFF, 16'h0800));
                while (u >= SURR_HI_MIN && u <= SURR_LO_MAX);
            end
        endcase
        return u;
    endfunction

    task automatic send_token(output bit ended);
        int         r;
        logic [7:0] b;
        ended = 1'b0;
        r = $urandom_range(99);
        if (r < 38) begin
            send_byte(plain_char());
        end else if (r < 50) begin
            send_byte(CH_BSLASH);
            send_byte(simple_escape($urandom_range(7)));
        end else if (r < 54) begin
            send_byte(CH_BSLASH);
            do b = 8'($urandom_range(255)); while (b == CH_LOW_U);
            send_byte(b);
        end else if (r < 74) begin
            send_unit(scalar_unit());
        end else if (r < 84) begin
            send_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
            send_unit(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));
        end else if (r < 88) begin
            send_unit(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));
        end else if (r < 93) begin
            send_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
        end else if (r < 96) begin
            send_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
            send_bad_group();
            ended = 1'b1;
        end else if (r < 98) begin
            send_bad_group();
            ended = 1'b1;
        end else begin
            send_byte(8'($urandom_range(CTL_MAX, 0)));
            ended = 1'b1;
        end
    endtask

    task automatic send_literal();
        bit ended;
        int n;
        int r;
        send_start(CH_QUOTE);
        n = $urandom_range(8, 1);
        ended = 1'b0;
        for (int i = 0; i < n && !ended; i++) send_token(ended);
        if (!ended) begin
            r = $urandom_range(99);
            if (r < 85) send_byte(CH_QUOTE);
            else if (r >= 95) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic send_noise();
        t_in x;
        x.in_byte = 8'($urandom_range(255));
        x.start_string = ($urandom_range(7) == 0);
        send(x);
    endtask

    task automatic random_phase(input int count);
        int target;
        target = n_sent + count;
        while (n_sent < target) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_literal();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(CH_UC_A);
        send_start(8'hFF);
        send_start(CH_QUOTE);
        send_byte(CH_SPACE);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_T);
        send_byte(CH_BSLASH);
        send_byte(8'h00);
        send_byte(CH_QUOTE);
        send_start(CH_QUOTE);
        send_unit(SURR_HI_MAX);
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_N);
        send_byte(CTL_MAX);
        send_start(CH_QUOTE);
        send_byte(8'h7E);
        send_start(CH_QUOTE);
        send_byte(CH_QUOTE);
        random_phase(ITEMS_PER_PHASE);
        drain();

        snd_idle = 67;
        rcv_idle = 15;
        random_phase(ITEMS_PER_PHASE);
        drain();

        snd_idle = 0;
        rcv_idle = 0;
        fork
            hold_receiver(STALL_CYCLES);
        join_none
        random_phase(ITEMS_PER_PHASE);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d input transactions; checked %0d text bytes, %0d string ends",
                 sb.n_inputs, sb.n_text, sb.n_ends);
        $display("and %0d malformed-input results across three idling mixes and a stall.",
                 sb.n_malformed);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_top.sv
bench/json_string_unescape_utf8_top_test.sv
